@@ src/bb3_pkg.sv @@
// Package with the shared constants, item types and divider tables of the 3x3 box blur.
`timescale 1ns / 1ps

package bb3_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT) + 1;

	localparam int FW_W  = 12;
	localparam int FH_W  = 13;
	localparam int CFG_W = 13;
	localparam int IDX_W = 1;

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [FW_W-1:0] RESET_WIDTH  = 12'd640;
	localparam logic [FH_W-1:0] RESET_HEIGHT = 13'd480;

	localparam int CH_W  = 8;
	localparam int PIX_W = 3 * CH_W;
	localparam int MEM_W = 2 * PIX_W;

	localparam int SUM_W       = 12;
	localparam int NUM_W       = 13;
	localparam int RECIP_W     = 18;
	localparam int RECIP_SHIFT = 18;
	localparam int PROD_W      = NUM_W + RECIP_W;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = FIFO_AW + 1;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic [2:0][PIX_W-1:0] column_t;

	typedef struct packed {
		logic            action;
		logic [CH_W-1:0] in_red;
		logic [CH_W-1:0] in_green;
		logic [CH_W-1:0] in_blue;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic            frame_end;
	} out_item_t;

	typedef struct packed {
		logic up_ok;
		logic down_ok;
		logic left_ok;
		logic right_ok;
	} tap_mask_t;

	typedef struct packed {
		logic             valid;
		logic             drain;
		pixel_t           pix;
		logic [COL_W-1:0] col;
		logic             emit;
		logic             row_end;
		tap_mask_t        mask;
		logic             frame_end;
	} s1_ctrl_t;

	typedef struct packed {
		logic                  valid;
		logic [2:0][SUM_W-1:0] sum;
		tap_mask_t             mask;
		logic                  frame_end;
	} sum_t;

	function automatic logic [3:0] tap_count(input tap_mask_t m);
		logic [1:0] nr;
		logic [1:0] nc;
		nr = 2'd1 + 2'(m.up_ok) + 2'(m.down_ok);
		nc = 2'd1 + 2'(m.left_ok) + 2'(m.right_ok);
		return 4'(nr) * 4'(nc);
	endfunction

	// Reciprocal of twice the tap count, rounded up, scaled by 2**RECIP_SHIFT.
	function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			4'd1:    r = 18'd131072;
			4'd2:    r = 18'd65536;
			4'd3:    r = 18'd43691;
			4'd4:    r = 18'd32768;
			4'd6:    r = 18'd21846;
			4'd9:    r = 18'd14564;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ src/bb3_if.sv @@
// Stream interfaces for the pixel channel and the result channel.
`timescale 1ns / 1ps

interface bb3_pix_if import bb3_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface bb3_res_if import bb3_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ src/box_blur_3x3_edge_aware.sv @@
// Top level of the edge-aware 3x3 box blur with its output queue.
//
// Pixels enter on the pixels channel in raster order, one item per cycle when the
// result queue has room. Each channel of a result is the rounded average of the
// in-frame pixels of the 3x3 neighborhood. A result leaves once the pixel below and
// to the right of its center has entered, so drain items (action set) must follow
// the last pixel of a frame to flush the final row; frame_end marks its last result.
// The frame size is set through the write port (register 0 width, register 1 height);
// a write restarts the frame; the user must make it only while the block is idle, which the block does not enforce.
// Throughput is one item per cycle while pixels is ready, set by the single line
// store access per item: one read and one write of the same entry. A result passes
// the control, sum and product registers and the queue before results offers it.
// Results wait in an eight-entry queue; when the receiver stalls, the queue fills
// and pixels stops taking items once eight results are outstanding.
// Reset clears the counters, the queue and the frame size to 640 by 480. The line
// store needs no clearing, since entries not yet written only feed masked taps.
`timescale 1ns / 1ps

module box_blur_3x3_edge_aware import bb3_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	bb3_pix_if.sink          pixels,
	bb3_res_if.source        results
);

	logic             accept;
	logic             rd_en;
	logic [COL_W-1:0] rd_addr;
	logic             emit_s0;
	s1_ctrl_t         ctrl_s1;
	logic [MEM_W-1:0] rd_data_s1;
	logic             wr_en;
	logic [COL_W-1:0] wr_addr;
	logic [MEM_W-1:0] wr_data;
	sum_t             sum_s2;
	logic             res_valid;
	out_item_t        res_item;

	out_item_t          fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   outstanding_q;
	logic               pop;

	assign pixels.ready = outstanding_q < CNT_W'(FIFO_DEPTH);
	assign accept       = pixels.valid && pixels.ready;

	bb3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (pixels.data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.emit_s0   (emit_s0),
		.ctrl_s1   (ctrl_s1)
	);

	bb3_line_mem u_line_mem (
		.clk        (clk),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_data_s1 (rd_data_s1)
	);

	bb3_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl_s1    (ctrl_s1),
		.rd_data_s1 (rd_data_s1),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.sum_s2     (sum_s2)
	);

	bb3_avg u_avg (
		.clk       (clk),
		.arst_n    (arst_n),
		.sum_s2    (sum_s2),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

	assign results.valid = cnt_q != '0;
	assign results.data  = fifo_q[rd_ptr_q];
	assign pop           = results.valid && results.ready;

	always_ff @(posedge clk) begin
		if (res_valid) begin
			fifo_q[wr_ptr_q] <= res_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q      <= '0;
			rd_ptr_q      <= '0;
			cnt_q         <= '0;
			outstanding_q <= '0;
		end else begin
			if (res_valid) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			case ({res_valid, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
			case ({emit_s0, pop})
				2'b10:   outstanding_q <= outstanding_q + CNT_W'(1);
				2'b01:   outstanding_q <= outstanding_q - CNT_W'(1);
				default: outstanding_q <= outstanding_q;
			endcase
		end
	end

	a_outstanding_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= CNT_W'(FIFO_DEPTH))
		else $error("More results outstanding than the queue can hold.");

	a_queue_within_credit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= outstanding_q)
		else $error("Queue holds more results than were promised.");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (cnt_q < CNT_W'(FIFO_DEPTH)) || pop)
		else $error("Result written into a full queue.");

endmodule

@@ src/bb3_ctrl.sv @@
// Frame registers, raster counters and per-item control for the box blur.
`timescale 1ns / 1ps

module bb3_ctrl import bb3_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             accept,
	input  in_item_t         item,
	output logic             rd_en,
	output logic [COL_W-1:0] rd_addr,
	output logic             emit_s0,
	output s1_ctrl_t         ctrl_s1
);

	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic [COL_W-1:0] ic_q;
	logic [ROW_W-1:0] ir_q;
	logic [COL_W-1:0] oc_q;
	logic [ROW_W-1:0] or_q;

	logic [FW_W-1:0]  eff_w;
	logic [FH_W-1:0]  eff_h;
	logic             complete;
	logic             live;
	logic             emit_end;
	logic             emit_mid;
	logic             emit;
	logic             fend;
	logic [FW_W-1:0]  ic_next;
	logic [FW_W-1:0]  oc_next;
	tap_mask_t        mask;

	always_comb begin
		if (fw_q == '0) begin
			eff_w = FW_W'(1);
		end else if (32'(fw_q) > MAX_WIDTH) begin
			eff_w = FW_W'(MAX_WIDTH);
		end else begin
			eff_w = fw_q;
		end
		if (fh_q == '0) begin
			eff_h = FH_W'(1);
		end else if (32'(fh_q) > MAX_HEIGHT) begin
			eff_h = FH_W'(MAX_HEIGHT);
		end else begin
			eff_h = fh_q;
		end
	end

	assign complete = 32'(ir_q) >= 32'(eff_h);
	assign live     = accept && (item.action == complete);
	assign emit_end = (ic_q == '0) && (ir_q >= ROW_W'(2));
	assign emit_mid = (ic_q != '0) && (ir_q >= ROW_W'(1));
	assign emit     = emit_end || emit_mid;
	assign ic_next  = FW_W'(ic_q) + FW_W'(1);
	assign oc_next  = FW_W'(oc_q) + FW_W'(1);

	assign mask.up_ok    = or_q != '0;
	assign mask.down_ok  = (32'(or_q) + 32'd1) < 32'(eff_h);
	assign mask.left_ok  = oc_q != '0;
	assign mask.right_ok = oc_next < eff_w;

	assign fend = emit && (32'(or_q) + 32'd1 == 32'(eff_h)) && (oc_next == eff_w);

	assign rd_en   = live;
	assign rd_addr = ic_q;
	assign emit_s0 = live && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= RESET_WIDTH;
			fh_q <= RESET_HEIGHT;
			ic_q <= '0;
			ir_q <= '0;
			oc_q <= '0;
			or_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FRAME_WIDTH: begin
					fw_q <= cfg_data[FW_W-1:0];
					ic_q <= '0;
					ir_q <= '0;
					oc_q <= '0;
					or_q <= '0;
				end
				REG_FRAME_HEIGHT: begin
					fh_q <= cfg_data[FH_W-1:0];
					ic_q <= '0;
					ir_q <= '0;
					oc_q <= '0;
					or_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (live) begin
			if (ic_next >= eff_w) begin
				ic_q <= '0;
				ir_q <= ir_q + ROW_W'(1);
			end else begin
				ic_q <= ic_next[COL_W-1:0];
			end
			if (fend) begin
				ic_q <= '0;
				ir_q <= '0;
				oc_q <= '0;
				or_q <= '0;
			end else if (emit) begin
				if (oc_next >= eff_w) begin
					oc_q <= '0;
					or_q <= or_q + ROW_W'(1);
				end else begin
					oc_q <= oc_next[COL_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid     <= live;
			ctrl_s1.drain     <= item.action;
			ctrl_s1.pix       <= {item.in_red, item.in_green, item.in_blue};
			ctrl_s1.col       <= ic_q;
			ctrl_s1.emit      <= emit;
			ctrl_s1.row_end   <= emit_end;
			ctrl_s1.mask      <= mask;
			ctrl_s1.frame_end <= fend;
		end
	end

	a_frame_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(live && fend) |=> (ir_q == '0 && ic_q == '0 && or_q == '0 && oc_q == '0))
		else $error("Counters not cleared after the last result of a frame.");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ir_q) <= 32'(eff_h) + 32'd2)
		else $error("Input row counter ran past the drain rows.");

endmodule

@@ src/bb3_line_mem.sv @@
// Line store holding the upper and middle rows, with write-first read of the same entry.
`timescale 1ns / 1ps

module bb3_line_mem import bb3_pkg::*; (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [COL_W-1:0] rd_addr,
	input  logic             wr_en,
	input  logic [COL_W-1:0] wr_addr,
	input  logic [MEM_W-1:0] wr_data,
	output logic [MEM_W-1:0] rd_data_s1
);

	logic [MEM_W-1:0] mem_q [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr) begin
				rd_data_s1 <= wr_data;
			end else begin
				rd_data_s1 <= mem_q[rd_addr];
			end
		end
	end

endmodule

@@ src/bb3_window.sv @@
// 3x3 window, line store write-back and masked channel sums.
`timescale 1ns / 1ps

module bb3_window import bb3_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  s1_ctrl_t         ctrl_s1,
	input  logic [MEM_W-1:0] rd_data_s1,
	output logic             wr_en,
	output logic [COL_W-1:0] wr_addr,
	output logic [MEM_W-1:0] wr_data,
	output sum_t             sum_s2
);

	column_t win_q [3];

	pixel_t                pix;
	column_t               new_col;
	column_t               taps [3];
	logic [2:0]            row_ok;
	logic [2:0]            col_ok;
	logic [2:0][SUM_W-1:0] sum_c;

	assign pix        = ctrl_s1.drain ? '0 : ctrl_s1.pix;
	assign new_col[0] = rd_data_s1[MEM_W-1:PIX_W];
	assign new_col[1] = rd_data_s1[PIX_W-1:0];
	assign new_col[2] = pix;

	assign wr_en   = ctrl_s1.valid && !ctrl_s1.drain;
	assign wr_addr = ctrl_s1.col;
	assign wr_data = {new_col[1], pix};

	// At a row end the centre is the last column, so the right tap repeats it and is masked.
	assign taps[0] = win_q[1];
	assign taps[1] = win_q[2];
	assign taps[2] = ctrl_s1.row_end ? win_q[2] : new_col;

	assign row_ok = {ctrl_s1.mask.down_ok, 1'b1, ctrl_s1.mask.up_ok};
	assign col_ok = {ctrl_s1.mask.right_ok, 1'b1, ctrl_s1.mask.left_ok};

	always_comb begin
		sum_c = '0;
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++) begin
				if (col_ok[j] && row_ok[i]) begin
					for (int k = 0; k < 3; k++) begin
						sum_c[k] = sum_c[k] +
							SUM_W'(taps[j][i][PIX_W-1-CH_W*k -: CH_W]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_s1.valid) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= new_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_s2 <= '0;
		end else begin
			sum_s2.valid     <= ctrl_s1.valid && ctrl_s1.emit;
			sum_s2.sum       <= sum_c;
			sum_s2.mask      <= ctrl_s1.mask;
			sum_s2.frame_end <= ctrl_s1.frame_end;
		end
	end

endmodule

@@ src/bb3_avg.sv @@
// Rounded division of the channel sums by the tap count through a reciprocal multiply.
`timescale 1ns / 1ps

module bb3_avg import bb3_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  sum_t      sum_s2,
	output logic      res_valid,
	output out_item_t res_item
);

	logic [3:0]              n;
	logic [RECIP_W-1:0]      rcp;
	logic [2:0][PROD_W-1:0]  prod_c;
	logic [2:0][PROD_W-1:0]  prod_s3;
	logic                    valid_s3;
	logic                    frame_end_s3;

	assign n   = tap_count(sum_s2.mask);
	assign rcp = recip(n);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod_c[k] = PROD_W'({sum_s2.sum[k], 1'b0} + NUM_W'(n)) * PROD_W'(rcp);
		end
	end

	always_ff @(posedge clk) begin
		prod_s3      <= prod_c;
		frame_end_s3 <= sum_s2.frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= sum_s2.valid;
		end
	end

	assign res_valid          = valid_s3;
	assign res_item.out_red   = prod_s3[0][RECIP_SHIFT +: CH_W];
	assign res_item.out_green = prod_s3[1][RECIP_SHIFT +: CH_W];
	assign res_item.out_blue  = prod_s3[2][RECIP_SHIFT +: CH_W];
	assign res_item.frame_end = frame_end_s3;

endmodule
